### design/psd_pkg.sv
// shared constants and types for the point to segment distance block
// no dependencies
package psd_pkg;

   localparam int COORD_BITS_DEF = 32;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_Z = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_END_X   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_END_Y   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_END_Z   = 3'd5;

   // pipeline control handed to the back-end units
   typedef struct packed {
      logic advance;
      logic valid;
   } ctl_type;

endpackage

### design/point_segment_distance_top.sv
// point to line / segment distance in 3d, fixed point, fully pipelined
// depends on psd_pkg, psd_div, psd_sqrt
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | point x/y/z, segment_mode
//   rsp     | out       | rsp_valid/rsp_ready  | distance
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// one item per clock while no waiting result stalls the pipeline, which holds the
// seven arithmetic stages, one divider stage per quotient bit and one root stage per bit
// reset clears the segment registers and all valid bits; csr_ready is always high
// a stalled result holds the pipeline only when its last stage holds an item too,
// so bubbles keep draining and new items keep entering behind a waiting result
module point_segment_distance_top import psd_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   input  logic                         req_segment_mode,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [COORD_BITS:0]          rsp_distance,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic signed [COORD_BITS-1:0] csr_data
);

   localparam int CW = COORD_BITS;
   localparam int PW = 2*CW;
   localparam int NW = 2*CW+2;
   localparam int HW = CW+1;
   localparam logic [CW-1:0] SIGN_BIT = {1'b1, {(CW-1){1'b0}}};

   // magnitude and sign of a - b for two's complement operands
   function automatic logic [CW:0] sdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic          neg;
      x = a ^ SIGN_BIT;
      y = b ^ SIGN_BIT;
      neg = (x < y);
      sdiff = {neg, neg ? (y - x) : (x - y)};
   endfunction

   logic advance;

   // segment registers
   logic [CW-1:0] start_ff [3];
   logic [CW-1:0] end_ff   [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            start_ff[k] <= '0;
            end_ff[k]   <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_START_X: start_ff[0] <= csr_data;
            REG_START_Y: start_ff[1] <= csr_data;
            REG_START_Z: start_ff[2] <= csr_data;
            REG_END_X:   end_ff[0]   <= csr_data;
            REG_END_Y:   end_ff[1]   <= csr_data;
            REG_END_Z:   end_ff[2]   <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // valid bits of the front stages
   logic [6:0] v_ff;
   logic [6:0] v_in;

   assign v_in = {v_ff[5:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= v_in;
      end
   end

   // stage 1: coordinate differences
   logic [CW-1:0] pnt [3];
   logic [CW:0]   ps_in [3];
   logic [CW:0]   es_in [3];
   logic [CW:0]   pe_d_in [3];
   logic [CW-1:0] pm1_ff [3];
   logic [CW-1:0] em1_ff [3];
   logic [CW-1:0] qm1_ff [3];
   logic [2:0]    pn1_ff;
   logic [2:0]    en1_ff;
   logic          mode1_ff;

   assign pnt[0] = req_point_x;
   assign pnt[1] = req_point_y;
   assign pnt[2] = req_point_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ps_in[k]   = sdiff(pnt[k], start_ff[k]);
         es_in[k]   = sdiff(end_ff[k], start_ff[k]);
         pe_d_in[k] = sdiff(pnt[k], end_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            pm1_ff[k] <= ps_in[k][CW-1:0];
            pn1_ff[k] <= ps_in[k][CW];
            em1_ff[k] <= es_in[k][CW-1:0];
            en1_ff[k] <= es_in[k][CW];
            qm1_ff[k] <= pe_d_in[k][CW-1:0];
         end
         mode1_ff <= req_segment_mode;
      end
   end

   // stage 2: component products
   logic [PW-1:0] pp2_ff [3];
   logic [PW-1:0] ee2_ff [3];
   logic [PW-1:0] pe2_ff [3];
   logic [PW-1:0] qq2_ff [3];
   logic [2:0]    sg2_ff;
   logic          mode2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            pp2_ff[k] <= PW'(pm1_ff[k]) * PW'(pm1_ff[k]);
            ee2_ff[k] <= PW'(em1_ff[k]) * PW'(em1_ff[k]);
            pe2_ff[k] <= PW'(pm1_ff[k]) * PW'(em1_ff[k]);
            qq2_ff[k] <= PW'(qm1_ff[k]) * PW'(qm1_ff[k]);
         end
         sg2_ff   <= pn1_ff ^ en1_ff;
         mode2_ff <= mode1_ff;
      end
   end

   // stage 3: squared norms and split dot product
   logic [NW-1:0] s3_in, e3_in, t3_in, pos3_in, neg3_in;
   logic [NW-1:0] s3_ff, e3_ff, t3_ff, pos3_ff, neg3_ff;
   logic          mode3_ff;

   always_comb begin
      s3_in   = NW'(pp2_ff[0]) + NW'(pp2_ff[1]) + NW'(pp2_ff[2]);
      e3_in   = NW'(ee2_ff[0]) + NW'(ee2_ff[1]) + NW'(ee2_ff[2]);
      t3_in   = NW'(qq2_ff[0]) + NW'(qq2_ff[1]) + NW'(qq2_ff[2]);
      pos3_in = '0;
      neg3_in = '0;
      for (int k = 0; k < 3; k++) begin
         if (sg2_ff[k]) begin
            neg3_in = neg3_in + NW'(pe2_ff[k]);
         end else begin
            pos3_in = pos3_in + NW'(pe2_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff    <= s3_in;
         e3_ff    <= e3_in;
         t3_ff    <= t3_in;
         pos3_ff  <= pos3_in;
         neg3_ff  <= neg3_in;
         mode3_ff <= mode2_ff;
      end
   end

   // stage 4: region select and dot product magnitude
   logic          before_start, past_end, degen, line4_in;
   logic [NW-1:0] rad4_in, d4_in;
   logic [NW-1:0] rad4_ff, d4_ff, s4_ff, e4_ff;
   logic          line4_ff;

   always_comb begin
      before_start = mode3_ff && (neg3_ff > pos3_ff);
      past_end     = mode3_ff && ({1'b0, pos3_ff} > ({1'b0, neg3_ff} + {1'b0, e3_ff}));
      degen        = (e3_ff == '0);
      line4_in     = !before_start && !past_end && !degen;
      rad4_in      = (!before_start && past_end) ? t3_ff : s3_ff;
      d4_in        = (pos3_ff >= neg3_ff) ? (pos3_ff - neg3_ff) : (neg3_ff - pos3_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         line4_ff <= line4_in;
         rad4_ff  <= rad4_in;
         d4_ff    <= d4_in;
         s4_ff    <= s3_ff;
         e4_ff    <= e3_ff;
      end
   end

   // stage 5: half-word partial products of d*d and s*e
   logic [NW-1:0] dhh5_ff, dhl5_ff, dll5_ff;
   logic [NW-1:0] shh5_ff, shl5_ff, slh5_ff, sll5_ff;
   logic [NW-1:0] rad5_ff, e5_ff;
   logic          line5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         dhh5_ff  <= NW'(d4_ff[NW-1:HW]) * NW'(d4_ff[NW-1:HW]);
         dhl5_ff  <= NW'(d4_ff[NW-1:HW]) * NW'(d4_ff[HW-1:0]);
         dll5_ff  <= NW'(d4_ff[HW-1:0])  * NW'(d4_ff[HW-1:0]);
         shh5_ff  <= NW'(s4_ff[NW-1:HW]) * NW'(e4_ff[NW-1:HW]);
         shl5_ff  <= NW'(s4_ff[NW-1:HW]) * NW'(e4_ff[HW-1:0]);
         slh5_ff  <= NW'(s4_ff[HW-1:0])  * NW'(e4_ff[NW-1:HW]);
         sll5_ff  <= NW'(s4_ff[HW-1:0])  * NW'(e4_ff[HW-1:0]);
         rad5_ff  <= rad4_ff;
         e5_ff    <= e4_ff;
         line5_ff <= line4_ff;
      end
   end

   // stage 6: assemble full products
   logic [2*NW-1:0] dd6_in, se6_in;
   logic [2*NW-1:0] dd6_ff, se6_ff;
   logic [NW-1:0]   rad6_ff, e6_ff;
   logic            line6_ff;

   always_comb begin
      dd6_in = {dhh5_ff, dll5_ff} + ({{(NW-1){1'b0}}, dhl5_ff, 1'b0} << HW);
      se6_in = {shh5_ff, sll5_ff} + ({{NW{1'b0}}, shl5_ff} << HW)
             + ({{NW{1'b0}}, slh5_ff} << HW);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dd6_ff   <= dd6_in;
         se6_ff   <= se6_in;
         rad6_ff  <= rad5_ff;
         e6_ff    <= e5_ff;
         line6_ff <= line5_ff;
      end
   end

   // stage 7: cross product squared, endpoint cases go through as x/1
   logic [2*NW-1:0] cross7_in, dvd7_in, dvd7_ff;
   logic [NW-1:0]   dvs7_in, dvs7_ff;

   always_comb begin
      cross7_in = (se6_ff > dd6_ff) ? (se6_ff - dd6_ff) : '0;
      dvd7_in   = line6_ff ? cross7_in : {{NW{1'b0}}, rad6_ff};
      dvs7_in   = line6_ff ? e6_ff : NW'(1);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dvd7_ff <= dvd7_in;
         dvs7_ff <= dvs7_in;
      end
   end

   // divider and square root
   ctl_type       div_ctl, sqrt_ctl;
   logic          quo_valid, root_valid;
   logic [NW-1:0] quotient;
   logic [HW-1:0] root;

   assign div_ctl.advance  = advance;
   assign div_ctl.valid    = v_ff[6];
   assign sqrt_ctl.advance = advance;
   assign sqrt_ctl.valid   = quo_valid;

   psd_div #(
      .NUM_BITS (NW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (div_ctl),
      .dividend  (dvd7_ff),
      .divisor   (dvs7_ff),
      .quo_valid (quo_valid),
      .quotient  (quotient)
   );

   psd_sqrt #(
      .ROOT_BITS (HW)
   ) u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .ctl_in     (sqrt_ctl),
      .radicand   (quotient),
      .root_valid (root_valid),
      .root       (root)
   );

   // output register
   logic          rsp_valid_ff;
   logic [HW-1:0] rsp_distance_ff;
   logic          out_load;

   assign out_load = rsp_ready || !rsp_valid_ff;
   assign advance  = out_load || !root_valid;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_distance_ff <= root;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

endmodule

### design/psd_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on psd_pkg; quotient must fit NUM_BITS (dividend high half below divisor)
module psd_div import psd_pkg::*; #(
   parameter int NUM_BITS = 2*COORD_BITS_DEF+2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl_in,
   input  logic [2*NUM_BITS-1:0] dividend,
   input  logic [NUM_BITS-1:0]   divisor,
   output logic                  quo_valid,
   output logic [NUM_BITS-1:0]   quotient
);

   localparam int N = NUM_BITS;

   logic [N-1:0] rem_ff  [N];
   logic [N-1:0] low_ff  [N];
   logic [N-1:0] dsr_ff  [N];
   logic [N-1:0] vld_ff;

   logic [N-1:0] rem_src [N];
   logic [N-1:0] low_src [N];
   logic [N-1:0] dsr_src [N];
   logic [N+1:0] diff    [N];
   logic [N-1:0] rem_in  [N];
   logic [N-1:0] low_in  [N];
   logic [N-1:0] vld_in;

   always_comb begin
      rem_src[0] = dividend[2*N-1:N];
      low_src[0] = dividend[N-1:0];
      dsr_src[0] = divisor;
      for (int k = 1; k < N; k++) begin
         rem_src[k] = rem_ff[k-1];
         low_src[k] = low_ff[k-1];
         dsr_src[k] = dsr_ff[k-1];
      end
      // low word shifts out dividend bits at the top, takes quotient bits at the bottom
      for (int k = 0; k < N; k++) begin
         diff[k]   = {1'b0, rem_src[k], low_src[k][N-1]} - {2'b00, dsr_src[k]};
         rem_in[k] = diff[k][N+1] ? {rem_src[k][N-2:0], low_src[k][N-1]} : diff[k][N-1:0];
         low_in[k] = {low_src[k][N-2:0], !diff[k][N+1]};
      end
   end

   assign vld_in = {vld_ff[N-2:0], ctl_in.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl_in.advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.advance) begin
         for (int k = 0; k < N; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            dsr_ff[k] <= dsr_src[k];
         end
      end
   end

   assign quo_valid = vld_ff[N-1];
   assign quotient  = low_ff[N-1];

endmodule

### design/psd_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on psd_pkg
module psd_sqrt import psd_pkg::*; #(
   parameter int ROOT_BITS = COORD_BITS_DEF+1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctl_type                ctl_in,
   input  logic [2*ROOT_BITS-1:0] radicand,
   output logic                   root_valid,
   output logic [ROOT_BITS-1:0]   root
);

   localparam int R = ROOT_BITS;

   logic [R+1:0]   rem_ff   [R];
   logic [R-1:0]   root_ff  [R];
   logic [2*R-1:0] rad_ff   [R];
   logic [R-1:0]   vld_ff;

   logic [R+1:0]   rem_src  [R];
   logic [R-1:0]   root_src [R];
   logic [2*R-1:0] rad_src  [R];
   logic [R+3:0]   trial    [R];
   logic [R+4:0]   diff     [R];
   logic [R+1:0]   rem_in   [R];
   logic [R-1:0]   root_in  [R];
   logic [2*R-1:0] rad_in   [R];
   logic [R-1:0]   vld_in;

   always_comb begin
      rem_src[0]  = '0;
      root_src[0] = '0;
      rad_src[0]  = radicand;
      for (int k = 1; k < R; k++) begin
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         rad_src[k]  = rad_ff[k-1];
      end
      // bring down two radicand bits, try root*4+1
      for (int k = 0; k < R; k++) begin
         trial[k]   = {rem_src[k], rad_src[k][2*R-1:2*R-2]};
         diff[k]    = {1'b0, trial[k]} - {3'b000, root_src[k], 2'b01};
         rem_in[k]  = diff[k][R+4] ? trial[k][R+1:0] : diff[k][R+1:0];
         root_in[k] = {root_src[k][R-2:0], !diff[k][R+4]};
         rad_in[k]  = {rad_src[k][2*R-3:0], 2'b00};
      end
   end

   assign vld_in = {vld_ff[R-2:0], ctl_in.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl_in.advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.advance) begin
         for (int k = 0; k < R; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
         end
      end
   end

   assign root_valid = vld_ff[R-1];
   assign root       = root_ff[R-1];

endmodule

### design/psd_checker.sv
// port-level checks for point_segment_distance_top, attached by bind
// depends on psd_pkg
module psd_checker import psd_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [COORD_BITS:0] rsp_distance,
   input logic                csr_valid,
   input logic                csr_ready
);

   // a waiting result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
      else $error("rsp item changed while stalled");

   // nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // with an empty output register the pipeline always takes an item
   a_room: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   // configuration writes are never held off
   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind point_segment_distance_top psd_checker #(.COORD_BITS(COORD_BITS)) u_psd_checker (.*);
